>>> rtl/pmq_pkg.sv
// shared types, codes and constants of the priority message queue
// used by pmq_cell and priority_message_queue; no dependencies
`default_nettype none

package pmq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int MAX_LENGTH  = 512;

    localparam int WORD_W     = 32;
    localparam int LENGTH_W   = 10;
    localparam int PRIO_W     = 16;
    localparam int STATUS_W   = 2;
    localparam int OCC_W      = 6;
    localparam int MAXMSG_W   = 6;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 1;

    // effective message size can exceed the length field when MAX_LENGTH is large
    localparam int SIZE_W = ($clog2(MAX_LENGTH + 1) > LENGTH_W) ?
                            $clog2(MAX_LENGTH + 1) : LENGTH_W;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_SIZE  = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic {
        KIND_SEND = 1'b0,
        KIND_RECV = 1'b1
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_MESSAGES = 1'b0,
        REG_MESSAGE_SIZE = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [WORD_W-1:0]   word;
        logic [PRIO_W-1:0]   prio;
        logic [LENGTH_W-1:0] len;
    } entry_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic   insert;
        logic   remove;
        entry_t entry;
    } cmd_t;

endpackage

`default_nettype wire

>>> rtl/pmq_cell.sv
// one slot of the sorted chain: holds an entry, keeps it, takes the new item,
// or takes a neighbor's entry; uses pmq_pkg
`default_nettype none

module pmq_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 6
) (
    input  wire logic                aclk,
    input  wire pmq_pkg::cmd_t       cmd,
    input  wire logic [CNT_W-1:0]    count,
    input  wire pmq_pkg::entry_t     left_entry,
    input  wire logic                left_stay,
    input  wire pmq_pkg::entry_t     right_entry,
    output pmq_pkg::entry_t          entry,
    output logic                     stay
);

    pmq_pkg::entry_t entry_reg;
    pmq_pkg::entry_t entry_next;
    logic            occupied;

    assign occupied = ({1'b0, count} > (CNT_W+1)'(IDX));
    // entry of equal or higher priority stays ahead of the new item
    assign stay     = occupied && (entry_reg.prio >= cmd.entry.prio);
    assign entry    = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (cmd.insert) begin
            if (stay) begin
                entry_next = entry_reg;
            end else if (left_stay) begin
                entry_next = cmd.entry;
            end else begin
                entry_next = left_entry;
            end
        end else if (cmd.remove) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

>>> rtl/priority_message_queue.sv
// top level of the priority message queue: request decode, limits, result register
// and the chain of pmq_cell slots; uses pmq_pkg
`default_nettype none

// Bounded priority message queue built as a chain of QUEUE_DEPTH slot cells kept
// sorted from the head (highest priority first, oldest first among equals). Every
// item, send or receive, is decoded and applied to all cells in the clock cycle it
// is accepted, so the block takes one item per clock; each item produces exactly one
// result, held in an output register. A new item is accepted whenever that register
// is empty or its result is being taken in the same cycle, so a stalled result side
// stalls the input after one item. Configuration writes take effect at the next item.
module priority_message_queue #(
    parameter int QUEUE_DEPTH = pmq_pkg::QUEUE_DEPTH
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              cfg_wr_en,
    input  wire logic [pmq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pmq_pkg::CFG_DATA_W-1:0]    cfg_wdata,

    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_kind,
    input  wire logic [pmq_pkg::WORD_W-1:0]        s_message_word,
    input  wire logic [pmq_pkg::LENGTH_W-1:0]      s_length,
    input  wire logic [pmq_pkg::PRIO_W-1:0]        s_priority_req,

    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [pmq_pkg::STATUS_W-1:0]           m_status,
    output logic [pmq_pkg::WORD_W-1:0]             m_out_word,
    output logic [pmq_pkg::LENGTH_W-1:0]           m_out_length,
    output logic [pmq_pkg::PRIO_W-1:0]             m_out_priority,
    output logic [pmq_pkg::OCC_W-1:0]              m_occupancy
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CAP_W = (CNT_W > pmq_pkg::MAXMSG_W) ? CNT_W : pmq_pkg::MAXMSG_W;

    logic [CAP_W-1:0]              cap_reg;
    logic [pmq_pkg::SIZE_W-1:0]    size_reg;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;

    logic                          m_valid_reg;
    pmq_pkg::status_t              status_reg;
    pmq_pkg::status_t              status_next;
    pmq_pkg::entry_t               result_reg;
    pmq_pkg::entry_t               result_next;
    logic [pmq_pkg::OCC_W-1:0]     occ_reg;

    logic                          accept;
    logic [pmq_pkg::SIZE_W-1:0]    len_ext;
    logic [CAP_W-1:0]              count_cap;
    logic [CAP_W-1:0]              count_next_cap;
    logic [CAP_W-1:0]              wr_cap;
    pmq_pkg::cmd_t                 cmd;

    pmq_pkg::entry_t               cell_entry [QUEUE_DEPTH];
    logic                          cell_stay  [QUEUE_DEPTH];

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign len_ext        = pmq_pkg::SIZE_W'(s_length);
    assign count_cap      = CAP_W'(count_reg);
    assign count_next_cap = CAP_W'(count_next);

    // capacity register holds min(max_messages, QUEUE_DEPTH)
    assign wr_cap = (CAP_W'(cfg_wdata[pmq_pkg::MAXMSG_W-1:0]) < CAP_W'(QUEUE_DEPTH)) ?
                    CAP_W'(cfg_wdata[pmq_pkg::MAXMSG_W-1:0]) : CAP_W'(QUEUE_DEPTH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg  <= CAP_W'(QUEUE_DEPTH);
            size_reg <= pmq_pkg::SIZE_W'(pmq_pkg::MAX_LENGTH);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                pmq_pkg::REG_MAX_MESSAGES: begin
                    cap_reg <= wr_cap;
                end
                pmq_pkg::REG_MESSAGE_SIZE: begin
                    if (pmq_pkg::SIZE_W'(cfg_wdata) < pmq_pkg::SIZE_W'(pmq_pkg::MAX_LENGTH)) begin
                        size_reg <= pmq_pkg::SIZE_W'(cfg_wdata);
                    end else begin
                        size_reg <= pmq_pkg::SIZE_W'(pmq_pkg::MAX_LENGTH);
                    end
                end
                default: begin
                    cap_reg <= cap_reg;
                end
            endcase
        end
    end

    // request decode
    always_comb begin
        cmd.insert       = 1'b0;
        cmd.remove       = 1'b0;
        cmd.entry.word   = s_message_word;
        cmd.entry.prio   = s_priority_req;
        cmd.entry.len    = s_length;
        status_next      = pmq_pkg::ST_OK;
        result_next      = '0;
        count_next       = count_reg;
        if (s_kind == pmq_pkg::KIND_SEND) begin
            if (len_ext > size_reg) begin
                status_next = pmq_pkg::ST_SIZE;
            end else if (count_cap >= cap_reg) begin
                status_next = pmq_pkg::ST_FULL;
            end else begin
                cmd.insert = accept;
                count_next = count_reg + CNT_W'(1);
            end
        end else begin
            if (len_ext < size_reg) begin
                status_next = pmq_pkg::ST_SIZE;
            end else if (count_reg == '0) begin
                status_next = pmq_pkg::ST_EMPTY;
            end else begin
                cmd.remove  = accept;
                result_next = cell_entry[0];
                count_next  = count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
            result_reg <= result_next;
            occ_reg    <= count_next_cap[pmq_pkg::OCC_W-1:0];
        end
    end

    // sorted chain, head at slot 0
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        pmq_pkg::entry_t left_entry;
        logic            left_stay;
        pmq_pkg::entry_t right_entry;

        if (i == 0) begin : g_head
            assign left_entry = cmd.entry;
            assign left_stay  = 1'b1;
        end else begin : g_mid
            assign left_entry = cell_entry[i-1];
            assign left_stay  = cell_stay[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_tail
            assign right_entry = cell_entry[i];
        end else begin : g_body
            assign right_entry = cell_entry[i+1];
        end

        pmq_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk        (aclk),
            .cmd         (cmd),
            .count       (count_reg),
            .left_entry  (left_entry),
            .left_stay   (left_stay),
            .right_entry (right_entry),
            .entry       (cell_entry[i]),
            .stay        (cell_stay[i])
        );
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_out_word     = result_reg.word;
    assign m_out_length   = result_reg.len;
    assign m_out_priority = result_reg.prio;
    assign m_occupancy    = occ_reg;

endmodule

`default_nettype wire
